// File: rtl/cjpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjpv_pkg - shared types and constants
// Formats, widths, register indexes, reset values and sequencer states for
// the cascaded joint position/velocity controller.
// ----------------------------------------------------------------------------
package cjpv_pkg;

	// Data formats
	localparam int DATA_WIDTH = 24;             // Q11.12 angles and speeds
	localparam int FRAC_BITS  = 12;
	localparam int GAIN_WIDTH = 16;             // unsigned Q8.8 gains
	localparam int GAIN_FRAC  = GAIN_WIDTH / 2;
	localparam int LIMIT_W    = DATA_WIDTH - 1; // speed limit and bands
	localparam int ACCEL_W    = 16;
	localparam int TORQUE_W   = 32;

	// Datapath widths
	localparam int ERR_W  = DATA_WIDTH + 1;         // target - angle, ev
	localparam int MA_W   = DATA_WIDTH + 2;         // multiplier signed operand
	localparam int PROD_W = MA_W + GAIN_WIDTH + 1;  // exact product / sum
	localparam int DEM_W  = PROD_W - GAIN_FRAC + 1; // shifted product - speed
	localparam int TQ_W   = PROD_W - GAIN_FRAC;     // torque before saturation

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = LIMIT_W;

	localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_DAMP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPD_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_BAND = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_BAND  = 3'd6;

	// Reset values
	localparam logic [GAIN_WIDTH-1:0] POS_GAIN_RST  = GAIN_WIDTH'(18 << GAIN_FRAC);
	localparam logic [GAIN_WIDTH-1:0] VEL_GAIN_RST  = GAIN_WIDTH'(15 << GAIN_FRAC);
	localparam logic [GAIN_WIDTH-1:0] VEL_DAMP_RST  = GAIN_WIDTH'(6 << GAIN_FRAC);
	localparam logic [LIMIT_W-1:0]    SPD_LIMIT_RST = LIMIT_W'(2 << FRAC_BITS);
	localparam logic [ACCEL_W-1:0]    ACCEL_RST     = '0;
	localparam logic [LIMIT_W-1:0]    NEAR_BAND_RST = LIMIT_W'((5 << FRAC_BITS) / 1000);
	localparam logic [LIMIT_W-1:0]    FAR_BAND_RST  = LIMIT_W'(1 << (FRAC_BITS - 1));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_DEM,
		ST_EV,
		ST_MUL_V,
		ST_MUL_D,
		ST_ACC,
		ST_SAT
	} state_t;

endpackage

// File: rtl/cjpv_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjpv_mul - shared gain multiplier
// Signed operand times unsigned Q8.8 gain, exact, with registered product.
// ----------------------------------------------------------------------------
module cjpv_mul
	import cjpv_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [MA_W-1:0]   op_a,
	input  logic [GAIN_WIDTH-1:0]    op_b,
	output logic signed [PROD_W-1:0] prod_s1
);

	logic signed [PROD_W-1:0] prod;

	assign prod = op_a * $signed({1'b0, op_b});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
		end
	end

endmodule

// File: rtl/cascaded_joint_position_velocity_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_joint_position_velocity_ctrl - cascaded P position / PD velocity loop
// One request per control tick: target angle, measured angle and speed, enable.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one request per control tick. The
//    block stalls its input while a request is in work.
//  - Output channel (out_valid / out_stall): one result per request, held in an
//    output register until taken.
//  - Config channel (cfg_valid / cfg_ready): always ready; write registers only
//    while the block is idle. Indexes past the register list are ignored.
//  - Timing: out_valid rises after the sequencer has walked its seven steps
//    (MUL_P, DEM, EV, MUL_V, MUL_D, ACC, SAT) through the one shared 26x17
//    multiplier; a new request is accepted only once the last has finished.
//  - If the output is still held when the next result is ready, the sequencer
//    waits in its last step; no result is dropped or overwritten.
//  - Reset (arst_n low, async): gains and bands return to defaults, the stored
//    velocity error clears, no result is pending.
// ----------------------------------------------------------------------------
module cascaded_joint_position_velocity_ctrl
	import cjpv_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] target_angle,
	input  logic signed [DATA_WIDTH-1:0] measured_angle,
	input  logic signed [DATA_WIDTH-1:0] measured_speed,
	input  logic                         torque_enable,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [TORQUE_W-1:0]   drive_torque,
	output logic                         torque_on,
	output logic [ACCEL_W-1:0]           accel_command,
	output logic signed [DATA_WIDTH-1:0] reported_speed,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [GAIN_WIDTH-1:0] pos_gain_q, vel_gain_q, vel_damp_q;
	logic [LIMIT_W-1:0]    spd_limit_q, near_band_q, far_band_q;
	logic [ACCEL_W-1:0]    accel_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_gain_q  <= POS_GAIN_RST;
			vel_gain_q  <= VEL_GAIN_RST;
			vel_damp_q  <= VEL_DAMP_RST;
			spd_limit_q <= SPD_LIMIT_RST;
			accel_q     <= ACCEL_RST;
			near_band_q <= NEAR_BAND_RST;
			far_band_q  <= FAR_BAND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POS_GAIN:  pos_gain_q  <= cfg_data[GAIN_WIDTH-1:0];
				REG_VEL_GAIN:  vel_gain_q  <= cfg_data[GAIN_WIDTH-1:0];
				REG_VEL_DAMP:  vel_damp_q  <= cfg_data[GAIN_WIDTH-1:0];
				REG_SPD_LIMIT: spd_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_ACCEL:     accel_q     <= cfg_data[ACCEL_W-1:0];
				REG_NEAR_BAND: near_band_q <= cfg_data[LIMIT_W-1:0];
				REG_FAR_BAND:  far_band_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	state_t state_q, state_d;
	logic   in_acc, out_free, out_load, mul_en;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mul_en   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = ST_MUL_P;
			end
			ST_MUL_P: begin
				mul_en  = 1'b1;
				state_d = ST_DEM;
			end
			ST_DEM:   state_d = ST_EV;
			ST_EV:    state_d = ST_MUL_V;
			ST_MUL_V: begin
				mul_en  = 1'b1;
				state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				mul_en  = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC:   state_d = ST_SAT;
			ST_SAT: begin
				// hold here until the output register is free
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath
	// ------------------------------------------------------------------
	logic signed [ERR_W-1:0]      err_q;       // target - measured
	logic signed [DATA_WIDTH-1:0] speed_q;
	logic                         enable_q;
	logic                         far_q;       // err above far band (signed)
	logic                         near_q;      // err below near band (signed)
	logic signed [DATA_WIDTH-1:0] dem_q;       // clamped velocity demand
	logic signed [ERR_W-1:0]      ev_q;        // velocity error
	logic signed [ERR_W-1:0]      prev_q;      // last tick's velocity error
	logic signed [PROD_W-1:0]     acc_q;

	logic signed [ERR_W-1:0]      err_in;
	logic signed [MA_W-1:0]       op_a;
	logic [GAIN_WIDTH-1:0]        op_b;
	logic signed [PROD_W-1:0]     prod_s1;
	logic signed [DEM_W-1:0]      dem_raw, lim_pos, lim_neg, dem_clamp;
	logic signed [TQ_W-1:0]       tq_full;
	logic [TQ_W-TORQUE_W:0]       tq_hi;
	logic signed [TORQUE_W-1:0]   tq_sat;

	assign err_in = ERR_W'(target_angle) - ERR_W'(measured_angle);

	// operand select for the shared multiplier
	always_comb begin
		op_a = MA_W'(err_q);
		op_b = pos_gain_q;
		unique case (state_q)
			ST_MUL_V: begin
				op_a = MA_W'(ev_q);
				op_b = vel_gain_q;
			end
			ST_MUL_D: begin
				op_a = MA_W'(ev_q) - MA_W'(prev_q);
				op_b = vel_damp_q;
			end
			default: ;
		endcase
	end

	cjpv_mul u_mul (
		.clk     (clk),
		.en      (mul_en),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod_s1)
	);

	// demand = floor(err * kp) - speed, clamped to +/- limit
	always_comb begin
		dem_raw = DEM_W'(prod_s1 >>> GAIN_FRAC) - DEM_W'(speed_q);
		lim_pos = $signed(DEM_W'(spd_limit_q));
		lim_neg = -lim_pos;
		priority if (dem_raw > lim_pos) dem_clamp = lim_pos;
		else if (dem_raw < lim_neg)     dem_clamp = lim_neg;
		else                            dem_clamp = dem_raw;
	end

	// torque saturation: upper bits must all match the sign
	always_comb begin
		tq_full = TQ_W'(acc_q >>> GAIN_FRAC);
		tq_hi   = tq_full[TQ_W-1:TORQUE_W-1];
		if ((&tq_hi) || !(|tq_hi)) begin
			tq_sat = tq_full[TORQUE_W-1:0];
		end else if (tq_full[TQ_W-1]) begin
			tq_sat = {1'b1, {(TORQUE_W-1){1'b0}}};
		end else begin
			tq_sat = {1'b0, {(TORQUE_W-1){1'b1}}};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q    <= err_in;
			speed_q  <= measured_speed;
			enable_q <= torque_enable;
			far_q    <= err_in > $signed(ERR_W'(far_band_q));
			near_q   <= err_in < $signed(ERR_W'(near_band_q));
		end
		if (state_q == ST_DEM) dem_q <= dem_clamp[DATA_WIDTH-1:0];
		if (state_q == ST_EV)  ev_q  <= ERR_W'(dem_q) - ERR_W'(speed_q);
		if (state_q == ST_MUL_D) acc_q <= prod_s1;          // ev * kv
		if (state_q == ST_ACC)   acc_q <= acc_q + prod_s1;  // + (ev - prev) * kd
	end

	// stored velocity error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (state_q == ST_ACC) begin
			prev_q <= ev_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			drive_torque   <= enable_q ? tq_sat : '0;
			torque_on      <= enable_q;
			accel_command  <= far_q ? accel_q : '0;
			reported_speed <= near_q ? '0 : speed_q;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_MUL_P)
		else $error("accepted request did not start the sequence");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SAT && out_valid && out_stall) |=> state_q == ST_SAT)
		else $error("result finished while output register still held");

	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !torque_on) |-> drive_torque == '0)
		else $error("torque driven while disabled");

	a_prev_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(prev_q) |-> $past(state_q) == ST_ACC)
		else $error("stored velocity error changed outside accumulate step");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the cascaded joint position/velocity loop
// A scoreboard class works out the torque, status, acceleration and gated
// speed for every accepted request and checks each result against it in
// order. Stimulus is directed corner cases followed by random requests over
// eight phases. Each phase applies its register setting and one of four
// pacings of the input and output sides.
// ----------------------------------------------------------------------------

import cjpv_pkg::*;

typedef struct {
	logic signed [TORQUE_W-1:0]   torque;
	logic                         on;
	logic [ACCEL_W-1:0]           accel;
	logic signed [DATA_WIDTH-1:0] speed;
} torque_result_t;

class torque_scoreboard;
	longint pos_gain, vel_gain, vel_damp, spd_limit, accel_set, near_band, far_band;
	longint last_speed_error;
	torque_result_t pending_torque[$];
	int mismatches;
	int accepted_requests;
	int checked_results;
	int register_writes;

	function new();
		pos_gain         = POS_GAIN_RST;
		vel_gain         = VEL_GAIN_RST;
		vel_damp         = VEL_DAMP_RST;
		spd_limit        = SPD_LIMIT_RST;
		accel_set        = ACCEL_RST;
		near_band        = NEAR_BAND_RST;
		far_band         = FAR_BAND_RST;
		last_speed_error = 0;
		mismatches       = 0;
		accepted_requests = 0;
		checked_results  = 0;
		register_writes  = 0;
	endfunction

	// gains and accel keep only their low 16 bits; unknown indexes are dropped
	function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		register_writes++;
		case (idx)
			REG_POS_GAIN:  pos_gain  = data[GAIN_WIDTH-1:0];
			REG_VEL_GAIN:  vel_gain  = data[GAIN_WIDTH-1:0];
			REG_VEL_DAMP:  vel_damp  = data[GAIN_WIDTH-1:0];
			REG_SPD_LIMIT: spd_limit = data[LIMIT_W-1:0];
			REG_ACCEL:     accel_set = data[ACCEL_W-1:0];
			REG_NEAR_BAND: near_band = data[LIMIT_W-1:0];
			REG_FAR_BAND:  far_band  = data[LIMIT_W-1:0];
			default: ;
		endcase
	endfunction

	function void note_request(logic signed [DATA_WIDTH-1:0] tgt_in,
			logic signed [DATA_WIDTH-1:0] ang_in, logic signed [DATA_WIDTH-1:0] spd_in,
			logic en);
		longint tgt, ang, spd, err, demand, ev, acc, tq;
		longint tq_max, tq_min;
		torque_result_t r;
		tq_max = 2147483647;
		tq_min = -tq_max - 1;
		tgt = tgt_in;
		ang = ang_in;
		spd = spd_in;
		err = tgt - ang;
		// outer loop: floor of the scaled position error, minus speed, clamped
		demand = ((err * pos_gain) >>> GAIN_FRAC) - spd;
		if (demand < -spd_limit)
			demand = -spd_limit;
		if (demand > spd_limit)
			demand = spd_limit;
		// inner PD loop on the velocity error
		ev  = demand - spd;
		acc = ev * vel_gain + (ev - last_speed_error) * vel_damp;
		tq  = acc >>> GAIN_FRAC;
		if (tq > tq_max)
			tq = tq_max;
		if (tq < tq_min)
			tq = tq_min;
		last_speed_error = ev;
		r.torque = en ? tq[TORQUE_W-1:0] : '0;
		r.on     = en;
		// band tests use the signed error
		r.accel  = (err > far_band) ? accel_set[ACCEL_W-1:0] : '0;
		r.speed  = (err < near_band) ? '0 : spd_in;
		pending_torque.push_back(r);
		accepted_requests++;
	endfunction

	task report_mismatch(string what, longint got, longint want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task check_result(logic signed [TORQUE_W-1:0] torque, logic on,
			logic [ACCEL_W-1:0] accel, logic signed [DATA_WIDTH-1:0] speed);
		torque_result_t w;
		if (pending_torque.size() == 0) begin
			report_mismatch("result with no request pending, torque", torque, 0);
		end else begin
			w = pending_torque.pop_front();
			checked_results++;
			if (torque !== w.torque)
				report_mismatch("drive_torque", torque, w.torque);
			if (on !== w.on)
				report_mismatch("torque_on", on, w.on);
			if (accel !== w.accel)
				report_mismatch("accel_command", accel, w.accel);
			if (speed !== w.speed)
				report_mismatch("reported_speed", speed, w.speed);
		end
	endtask
endclass

module testbench;

	localparam int CLK_HALF         = 4;
	localparam int RESET_CYCLES     = 8;
	localparam int NUM_PHASES       = 8;
	localparam int RANDOM_PER_PHASE = 241;
	localparam int DRAIN_CYCLES     = 24;
	localparam int CYCLE_LIMIT      = 400000;  // slowest legal run is well below this

	// index past the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam logic signed [DATA_WIDTH-1:0] ANGLE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] ANGLE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [CFG_W-1:0]             CFG_ONES  = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic signed [DATA_WIDTH-1:0] target_angle = '0;
	logic signed [DATA_WIDTH-1:0] measured_angle = '0;
	logic signed [DATA_WIDTH-1:0] measured_speed = '0;
	logic                         torque_enable = 1'b0;

	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [TORQUE_W-1:0]   drive_torque;
	logic                         torque_on;
	logic [ACCEL_W-1:0]           accel_command;
	logic signed [DATA_WIDTH-1:0] reported_speed;

	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_W-1:0]             cfg_data = '0;

	torque_scoreboard sb = new();

	int send_idle_pct = 0;   // chance per cycle that the request side holds back
	int stall_pct     = 0;   // chance per cycle that the result side stalls
	int cycle_count   = 0;

	cascaded_joint_position_velocity_ctrl uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.target_angle   (target_angle),
		.measured_angle (measured_angle),
		.measured_speed (measured_speed),
		.torque_enable  (torque_enable),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_torque   (drive_torque),
		.torque_on      (torque_on),
		.accel_command  (accel_command),
		.reported_speed (reported_speed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, sb.pending_torque.size());
			$display("cascaded_joint_position_velocity_ctrl: mismatch");
			$finish;
		end
	end

	// Result side back-pressure, random per cycle.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Monitors. Everything is sampled at the edge, so they see the pre-edge
	// values of both the bench and the block outputs.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request(target_angle, measured_angle, measured_speed, torque_enable);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(drive_torque, torque_on, accel_command, reported_speed);
		if (arst_n && cfg_valid && cfg_ready)
			sb.write_register(cfg_index, cfg_data);
	end

	// Present one request and hold it until accepted. in_valid is left high on
	// return so a back-to-back request never toggles it within one step.
	task send_request(logic signed [DATA_WIDTH-1:0] tgt, logic signed [DATA_WIDTH-1:0] ang,
			logic signed [DATA_WIDTH-1:0] spd, logic en);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		target_angle   <= tgt;
		measured_angle <= ang;
		measured_speed <= spd;
		torque_enable  <= en;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// One register write; the cycle after it is spent with cfg_valid low.
	task write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop requesting and wait until every expected result has come back.
	// One edge first, so the monitor has logged the last accepted request.
	task wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_torque.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] rand_gain();
		logic [CFG_W-1:0] v;
		v = CFG_W'($urandom);   // upper bits are junk the block must mask
		case ($urandom_range(5))
			0: v[GAIN_WIDTH-1:0] = '0;
			1: v[GAIN_WIDTH-1:0] = '1;
			2: v[GAIN_WIDTH-1:0] = GAIN_WIDTH'($urandom_range(0, 4096));
			default: v[GAIN_WIDTH-1:0] = GAIN_WIDTH'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [CFG_W-1:0] rand_band();
		case ($urandom_range(5))
			0: return '0;
			1: return CFG_ONES;
			2: return CFG_W'($urandom_range(0, 64));
			3: return CFG_W'($urandom_range(0, 8192));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	// Half extremes, zero and values near zero, the other half full range.
	function automatic logic signed [DATA_WIDTH-1:0] rand_value();
		int v;
		case ($urandom_range(9))
			0: return ANGLE_MAX;
			1: return ANGLE_MIN;
			2: return '0;
			3, 4: begin
				v = $urandom_range(0, 16383);
				return DATA_WIDTH'(v - 8192);
			end
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	// Position error offsets, some clustered on the two band edges.
	function automatic longint rand_offset();
		longint d;
		case ($urandom_range(7))
			0: d = sb.near_band - 1 + longint'($urandom_range(0, 2));
			1: d = sb.far_band - 1 + longint'($urandom_range(0, 2));
			2: d = -longint'($urandom_range(1, 4096));
			3: d = longint'($urandom_range(0, 4096));
			default: d = longint'($urandom_range(0, 65535)) - 32768;
		endcase
		return d;
	endfunction

	task apply_phase_config(int phase);
		case (phase)
			0: ;  // reset defaults
			1: begin
				// everything at the top; gains get all-ones data and keep 16 bits
				write_config(REG_POS_GAIN, CFG_ONES);
				write_config(REG_VEL_GAIN, CFG_ONES);
				write_config(REG_VEL_DAMP, CFG_ONES);
				write_config(REG_SPD_LIMIT, CFG_ONES);
				write_config(REG_ACCEL, CFG_ONES);
				write_config(REG_NEAR_BAND, CFG_ONES);
				write_config(REG_FAR_BAND, CFG_ONES);
				// no such register: nothing may change
				write_config(REG_UNUSED, '0);
			end
			2: begin
				write_config(REG_POS_GAIN, '0);
				write_config(REG_VEL_GAIN, '0);
				write_config(REG_VEL_DAMP, '0);
				write_config(REG_SPD_LIMIT, '0);
				write_config(REG_ACCEL, '0);
				write_config(REG_NEAR_BAND, '0);
				write_config(REG_FAR_BAND, '0);
			end
			default: begin
				write_config(REG_POS_GAIN, rand_gain());
				write_config(REG_VEL_GAIN, rand_gain());
				write_config(REG_VEL_DAMP, rand_gain());
				write_config(REG_SPD_LIMIT, rand_band());
				write_config(REG_ACCEL, rand_gain());
				write_config(REG_NEAR_BAND, rand_band());
				write_config(REG_FAR_BAND, rand_band());
				if ($urandom_range(1))
					write_config(REG_UNUSED, CFG_W'($urandom));
			end
		endcase
	endtask

	initial begin
		logic signed [DATA_WIDTH-1:0] tg, ms, spd;
		logic en;
		int hold_left;
		int mode;

		tg = '0;
		ms = '0;
		spd = '0;
		en = 1'b0;
		hold_left = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0)
				wait_drained();
			apply_phase_config(p);

			// pacing: none, sender idle, receiver stalling, both
			mode = p % 4;
			send_idle_pct = (mode == 1) ? 70 : (mode == 3) ? 36 : 0;
			stall_pct     = (mode == 2) ? 70 : (mode == 3) ? 36 : 0;

			if (p == 0) begin
				// defaults: zero, disable, angle and speed extremes
				send_request('0, '0, '0, 1'b0);
				send_request('0, '0, '0, 1'b1);
				send_request(ANGLE_MAX, ANGLE_MIN, '0, 1'b1);
				send_request(ANGLE_MIN, ANGLE_MAX, '0, 1'b1);
				send_request('0, '0, ANGLE_MAX, 1'b1);
				send_request('0, '0, ANGLE_MIN, 1'b1);
				send_request(ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, 1'b0);
				// near band edge: error equal to the band passes speed through
				send_request(24'sd20, '0, 24'sd100, 1'b1);
				send_request(24'sd19, '0, 24'sd100, 1'b1);
				// negative error: speed zeroed, even though its size is large
				send_request(-24'sd1, '0, 24'sd100, 1'b1);
				send_request(-24'sd5000, '0, -24'sd300, 1'b1);
				// far band edge
				send_request(24'sd2048, '0, -24'sd5, 1'b1);
				send_request(24'sd2049, '0, -24'sd5, 1'b1);
				// same request twice: derivative term goes to zero
				send_request(24'sd4000, 24'sd1000, 24'sd700, 1'b1);
				send_request(24'sd4000, 24'sd1000, 24'sd700, 1'b1);
			end else if (p == 1) begin
				// full gains: torque saturates both ways
				send_request(ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, 1'b1);
				send_request(ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, 1'b1);
				send_request(ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, 1'b0);
				// far and near bands at their maximum
				send_request(ANGLE_MAX, '0, 24'sd77, 1'b1);
				send_request(ANGLE_MAX, -24'sd1, 24'sd77, 1'b1);
				send_request(ANGLE_MAX - 24'sd1, '0, 24'sd77, 1'b1);
				send_request('0, '0, '0, 1'b1);
			end

			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (hold_left > 0) begin
					// steady inputs: the stored velocity error catches up
					hold_left--;
				end else begin
					ms  = rand_value();
					spd = rand_value();
					if ($urandom_range(1))
						tg = ms + DATA_WIDTH'(rand_offset());
					else
						tg = rand_value();
					en = ($urandom_range(3) != 0);
					if ($urandom_range(7) == 0)
						hold_left = $urandom_range(1, 3);
				end
				send_request(tg, ms, spd, en);
			end
		end

		wait_drained();

		$display("%0d requests checked against %0d results in %0d phases,",
			sb.accepted_requests, sb.checked_results, NUM_PHASES);
		$display("%0d register writes including ignored indexes and masked data",
			sb.register_writes);
		if (sb.mismatches == 0 && sb.pending_torque.size() == 0) begin
			$display("cascaded_joint_position_velocity_ctrl: match");
		end else begin
			$display("cascaded_joint_position_velocity_ctrl: mismatch");
		end
		$finish;
	end

endmodule
